[sv/kmg_pkg.sv]
package kmg_pkg;

    // Matrix geometry
    localparam int NUM_ROWS = 8;
    localparam int NUM_COLS = 16;
    localparam int COL_W    = $clog2(NUM_COLS);
    localparam int CNT_W    = $clog2(NUM_COLS + 1);
    localparam int ROWCNT_W = $clog2(NUM_ROWS + 1);

    // Register reset values
    localparam logic [3:0] ROWS_RESET = 4'd8;
    localparam logic [4:0] COLS_RESET = 5'd16;

    // Register indexes
    localparam logic REG_ACTIVE_ROWS = 1'b0;
    localparam logic REG_ACTIVE_COLS = 1'b1;

    typedef struct packed {
        logic [3:0] column_index;
        logic [7:0] row_bits;
        logic       frame_end;
    } in_t;

    typedef struct packed {
        logic [3:0] out_column;
        logic [7:0] accepted_bits;
        logic       last_column;
    } out_t;

    // Effective geometry handed from the register block to the sequencer
    typedef struct packed {
        logic [CNT_W-1:0]    ncols;
        logic [NUM_ROWS-1:0] rmask;
    } geom_t;

    // Shared unit result
    typedef struct packed {
        logic [NUM_ROWS-1:0] once_next;
        logic [NUM_ROWS-1:0] twice_next;
        logic [NUM_ROWS-1:0] acc;
    } unit_out_t;

endpackage

[sv/kmg_cfg.sv]
module kmg_cfg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output kmg_pkg::geom_t      geom
);

    logic [3:0] rows_reg;
    logic [4:0] cols_reg;
    logic       wr_en;
    logic [kmg_pkg::ROWCNT_W-1:0] nrows;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    // Store register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= kmg_pkg::ROWS_RESET;
            cols_reg <= kmg_pkg::COLS_RESET;
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                kmg_pkg::REG_ACTIVE_ROWS: rows_reg <= pwdata[3:0];
                kmg_pkg::REG_ACTIVE_COLS: cols_reg <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        unique case (paddr[2])
            kmg_pkg::REG_ACTIVE_ROWS: prdata = {28'd0, rows_reg};
            kmg_pkg::REG_ACTIVE_COLS: prdata = {27'd0, cols_reg};
            default:                  prdata = 32'd0;
        endcase
    end

    // Clamp counts to 1..size and build the row mask
    always_comb
    begin
        if (rows_reg == 4'd0)
            nrows = kmg_pkg::ROWCNT_W'(1);
        else if ({1'b0, rows_reg} > 5'(kmg_pkg::NUM_ROWS))
            nrows = kmg_pkg::ROWCNT_W'(kmg_pkg::NUM_ROWS);
        else
            nrows = kmg_pkg::ROWCNT_W'(rows_reg);

        if (cols_reg == 5'd0)
            geom.ncols = kmg_pkg::CNT_W'(1);
        else if ({1'b0, cols_reg} > 6'(kmg_pkg::NUM_COLS))
            geom.ncols = kmg_pkg::CNT_W'(kmg_pkg::NUM_COLS);
        else
            geom.ncols = kmg_pkg::CNT_W'(cols_reg);

        for (int r = 0; r < kmg_pkg::NUM_ROWS; r++)
            geom.rmask[r] = (kmg_pkg::ROWCNT_W'(r) < nrows);
    end

endmodule

[sv/kmg_unit.sv]
module kmg_unit (
    input  logic [kmg_pkg::NUM_ROWS-1:0] col_bits,
    input  logic [kmg_pkg::NUM_ROWS-1:0] prev_bits,
    input  logic [kmg_pkg::NUM_ROWS-1:0] rmask,
    input  logic [kmg_pkg::NUM_ROWS-1:0] once,
    input  logic [kmg_pkg::NUM_ROWS-1:0] twice,
    output kmg_pkg::unit_out_t           res
);

    logic [kmg_pkg::NUM_ROWS-1:0] pressed;
    logic [kmg_pkg::NUM_ROWS-1:0] fresh;
    logic                         col_multi;

    // Row tally: mark rows seen in at least one column, then in two or more
    assign res.once_next  = once | col_bits;
    assign res.twice_next = twice | (once & col_bits);

    // Column verdict: keep held keys, drop new keys on a crowded row and column
    assign pressed   = col_bits & rmask;
    assign fresh     = pressed & ~prev_bits;
    assign col_multi = (pressed & (pressed - 1'b1)) != '0;
    assign res.acc   = (pressed & prev_bits)
                     | (fresh & ~(twice & {kmg_pkg::NUM_ROWS{col_multi}}));

endmodule

[sv/key_matrix_ghost_filter.sv]
// Timing: an item without frame_end is taken and gives no result.
// An item with frame_end starts a row tally pass over the active columns
// and then an evaluation pass over them; results appear one per cycle, each
// registered from one evaluated column, and the last is marked by last_column.
// Throughput: one item per cycle while not busy; a frame_end item holds busy through both passes.
// Reset clears the frame store, previous masks and control state; the receiver cannot stall.
module key_matrix_ghost_filter (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  kmg_pkg::in_t    item,
    output logic            result_valid,
    output kmg_pkg::out_t   result,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [2:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_TALLY = 2'd1;
    localparam logic [1:0] ST_EVAL  = 2'd2;

    kmg_pkg::geom_t     geom;
    kmg_pkg::unit_out_t unit_res;

    logic [1:0]                   state_reg, state_next;
    logic [kmg_pkg::COL_W-1:0]    cnt_reg, cnt_next;
    logic [kmg_pkg::NUM_ROWS-1:0] once_reg, once_next;
    logic [kmg_pkg::NUM_ROWS-1:0] twice_reg, twice_next;
    logic [kmg_pkg::NUM_ROWS-1:0] store_reg [kmg_pkg::NUM_COLS];
    logic [kmg_pkg::NUM_ROWS-1:0] prev_reg  [kmg_pkg::NUM_COLS];
    logic                         rvalid_reg;
    kmg_pkg::out_t                result_reg;

    logic                         accept;
    logic                         last_col;
    logic [kmg_pkg::NUM_ROWS-1:0] cur_store;
    logic [kmg_pkg::NUM_ROWS-1:0] cur_prev;

    kmg_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .geom    (geom)
    );

    kmg_unit u_unit (
        .col_bits  (cur_store),
        .prev_bits (cur_prev),
        .rmask     (geom.rmask),
        .once      (once_reg),
        .twice     (twice_reg),
        .res       (unit_res)
    );

    assign busy      = (state_reg != ST_IDLE);
    assign accept    = start & ~busy;
    assign cur_store = store_reg[cnt_reg];
    assign cur_prev  = prev_reg[cnt_reg];
    assign last_col  = ({1'b0, cnt_reg} == kmg_pkg::CNT_W'(geom.ncols - 1'b1));

    assign result_valid = rvalid_reg;
    assign result       = result_reg;

    // Sequence the tally and evaluation passes
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        once_next  = once_reg;
        twice_next = twice_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && item.frame_end)
                begin
                    state_next = ST_TALLY;
                    cnt_next   = '0;
                    once_next  = '0;
                    twice_next = '0;
                end
            end
            ST_TALLY:
            begin
                once_next  = unit_res.once_next;
                twice_next = unit_res.twice_next;
                if (last_col)
                begin
                    state_next = ST_EVAL;
                    cnt_next   = '0;
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            ST_EVAL:
            begin
                if (last_col)
                    state_next = ST_IDLE;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            once_reg   <= '0;
            twice_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            once_reg   <= once_next;
            twice_reg  <= twice_next;
            rvalid_reg <= (state_reg == ST_EVAL);
        end
    end

    // Load the result register once for each evaluated column
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_EVAL)
        begin
            result_reg.out_column    <= cnt_reg;
            result_reg.accepted_bits <= unit_res.acc;
            result_reg.last_column   <= last_col;
        end
    end

    // Collect the frame; clear it once the last column is evaluated
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < kmg_pkg::NUM_COLS; i++)
                store_reg[i] <= '0;
        end
        else if (state_reg == ST_EVAL && last_col)
        begin
            for (int i = 0; i < kmg_pkg::NUM_COLS; i++)
                store_reg[i] <= '0;
        end
        else if (accept)
        begin
            for (int i = 0; i < kmg_pkg::NUM_COLS; i++)
            begin
                if ({1'b0, item.column_index} == kmg_pkg::CNT_W'(i)
                    && kmg_pkg::CNT_W'(i) < geom.ncols)
                    store_reg[i] <= store_reg[i] | (item.row_bits & geom.rmask);
            end
        end
    end

    // Update the previous-frame masks; zero the inactive columns at frame end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < kmg_pkg::NUM_COLS; i++)
                prev_reg[i] <= '0;
        end
        else if (state_reg == ST_EVAL)
        begin
            for (int i = 0; i < kmg_pkg::NUM_COLS; i++)
            begin
                if (kmg_pkg::COL_W'(i) == cnt_reg)
                    prev_reg[i] <= unit_res.acc;
                else if (last_col && kmg_pkg::CNT_W'(i) >= geom.ncols)
                    prev_reg[i] <= '0;
            end
        end
    end

    // A frame end always starts a pass
    a_frame_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept && item.frame_end |=> busy)
        else $error("frame end did not start a pass");

    // The last result of a frame leaves the block idle
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.last_column |-> !busy)
        else $error("block still busy after last result");

    // Results other than the last come while the pass is still running
    a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.last_column |-> busy)
        else $error("pass ended before last result");

    // Results are only produced from the evaluation pass
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(state_reg) == ST_EVAL)
        else $error("result outside evaluation pass");

endmodule
